/* rtl/core/matrix_vector_transform_4x4_core_defines.svh */
// Assertion macros shared by the core RTL.
`ifndef MATRIX_VECTOR_TRANSFORM_4X4_CORE_DEFINES_SVH
`define MATRIX_VECTOR_TRANSFORM_4X4_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MVT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mvt assertion failed");

// Next-cycle implication.
`define MVT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mvt assertion failed");

`else

`define MVT_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MVT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/mvt_pkg.sv */
`default_nettype none

package mvt_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int NUM_ROWS   = 4;
   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 2 * DATA_W;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int PAIR_W     = PROD_W + 1;
   localparam int SUM_W      = PROD_W + 2;
   localparam int SHIFT_W    = SUM_W - FRAC_BITS;

   typedef logic signed [DATA_W-1:0]  comp_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [PAIR_W-1:0]  pair_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   typedef comp_type [NUM_ROWS-1:0]                vec_type;
   typedef comp_type [NUM_ROWS-1:0][NUM_ROWS-1:0]  mat_type;
   typedef prod_type [NUM_ROWS-1:0][NUM_ROWS-1:0]  prod_mat_type;
   typedef pair_type [NUM_ROWS-1:0][1:0]           pair_mat_type;
   typedef sum_type  [NUM_ROWS-1:0]                sum_vec_type;

   localparam comp_type FIX_ONE = comp_type'(1) << FRAC_BITS;
   localparam comp_type SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam comp_type SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // CSR register map
   localparam logic [CSR_IDX_W-1:0] REG_ROW0_COLS01 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_ROW0_COLS23 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_COLS01 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_COLS23 = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_COLS01 = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_COLS23 = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_ROW3_COLS01 = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_ROW3_COLS23 = CSR_IDX_W'(7);

endpackage

`default_nettype wire

/* rtl/core/mvt_req_if.sv */
`default_nettype none

interface mvt_req_if;
   import mvt_pkg::*;

   logic     valid;
   logic     ready;
   comp_type vec_x;
   comp_type vec_y;
   comp_type vec_z;
   comp_type vec_w;

   modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_w,
                   input ready);
   modport sink   (input valid, input vec_x, input vec_y, input vec_z, input vec_w,
                   output ready);
endinterface

`default_nettype wire

/* rtl/core/mvt_rsp_if.sv */
`default_nettype none

interface mvt_rsp_if;
   import mvt_pkg::*;

   logic     valid;
   logic     ready;
   comp_type out_x;
   comp_type out_y;
   comp_type out_z;
   comp_type out_w;
   logic     clipped;

   modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                   output clipped, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                   input clipped, output ready);
endinterface

`default_nettype wire

/* rtl/core/mvt_mul.sv */
`default_nettype none
`include "matrix_vector_transform_4x4_core_defines.svh"

// Sixteen 32x32 signed multipliers, one per matrix entry, registered.
module mvt_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  valid_i,
   output      logic                  ready_o,
   input  wire mvt_pkg::vec_type      vec_i,
   input  wire mvt_pkg::mat_type      mat_i,
   output      logic                  valid_o,
   input  wire logic                  ready_i,
   output      mvt_pkg::prod_mat_type prod_o
);
   import mvt_pkg::*;

   logic         valid_ff;
   prod_mat_type prod_ff;
   prod_mat_type prod_in;

   assign ready_o = !valid_ff || ready_i;

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_ROWS; c++) begin
            prod_in[r][c] = PROD_W'(mat_i[r][c]) * PROD_W'(vec_i[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_o) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_i && ready_o) begin
         prod_ff <= prod_in;
      end
   end

   assign valid_o = valid_ff;
   assign prod_o  = prod_ff;

   `MVT_ASSERT_NEXT(a_mul_hold, clock, reset, valid_ff && !ready_i, valid_ff && $stable(prod_ff))

endmodule

`default_nettype wire

/* rtl/core/mvt_sum.sv */
`default_nettype none

// Two-level adder tree per row: pairs of products, then the row total.
module mvt_sum (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  valid_i,
   output      logic                  ready_o,
   input  wire mvt_pkg::prod_mat_type prod_i,
   output      logic                  valid_o,
   input  wire logic                  ready_i,
   output      mvt_pkg::sum_vec_type  sum_o
);
   import mvt_pkg::*;

   logic         pair_valid_ff;
   logic         sum_valid_ff;
   logic         pair_ready;
   pair_mat_type pair_ff;
   pair_mat_type pair_in;
   sum_vec_type  sum_ff;
   sum_vec_type  sum_in;

   assign pair_ready = !sum_valid_ff || ready_i;
   assign ready_o    = !pair_valid_ff || pair_ready;

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         pair_in[r][0] = PAIR_W'($signed(prod_i[r][0])) + PAIR_W'($signed(prod_i[r][1]));
         pair_in[r][1] = PAIR_W'($signed(prod_i[r][2])) + PAIR_W'($signed(prod_i[r][3]));
         sum_in[r]     = SUM_W'($signed(pair_ff[r][0])) + SUM_W'($signed(pair_ff[r][1]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (ready_o) begin
            pair_valid_ff <= valid_i;
         end
         if (pair_ready) begin
            sum_valid_ff <= pair_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (valid_i && ready_o) begin
         pair_ff <= pair_in;
      end
      if (pair_valid_ff && pair_ready) begin
         sum_ff <= sum_in;
      end
   end

   assign valid_o = sum_valid_ff;
   assign sum_o   = sum_ff;

endmodule

`default_nettype wire

/* rtl/core/mvt_sat.sv */
`default_nettype none
`include "matrix_vector_transform_4x4_core_defines.svh"

// Floor back to the output format, saturate, and hold the result.
module mvt_sat (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 valid_i,
   output      logic                 ready_o,
   input  wire mvt_pkg::sum_vec_type sum_i,
   output      logic                 valid_o,
   input  wire logic                 ready_i,
   output      mvt_pkg::vec_type     res_o,
   output      logic                 clipped_o
);
   import mvt_pkg::*;

   localparam int HI_W = SHIFT_W - DATA_W + 1;

   logic                          valid_ff;
   vec_type                       res_ff;
   vec_type                       res_in;
   logic                          clipped_ff;
   logic                          clipped_in;
   logic [NUM_ROWS-1:0]           fits;
   logic [NUM_ROWS-1:0][SHIFT_W-1:0] shifted;
   logic [NUM_ROWS-1:0][HI_W-1:0] hi_bits;

   assign ready_o = !valid_ff || ready_i;

   // Dropping the low fraction bits of a two's complement value is a floor.
   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         shifted[r] = sum_i[r][SUM_W-1:FRAC_BITS];
         hi_bits[r] = shifted[r][SHIFT_W-1:DATA_W-1];
         fits[r]    = (&hi_bits[r]) || !(|hi_bits[r]);
         if (fits[r]) begin
            res_in[r] = shifted[r][DATA_W-1:0];
         end else if (shifted[r][SHIFT_W-1]) begin
            res_in[r] = SAT_MIN;
         end else begin
            res_in[r] = SAT_MAX;
         end
      end
      clipped_in = !(&fits);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_o) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_i && ready_o) begin
         res_ff     <= res_in;
         clipped_ff <= clipped_in;
      end
   end

   assign valid_o   = valid_ff;
   assign res_o     = res_ff;
   assign clipped_o = clipped_ff;

   `MVT_ASSERT_NOW(a_clip_extreme, clock, reset, valid_ff && clipped_ff, res_ff[0] == SAT_MAX || res_ff[0] == SAT_MIN || res_ff[1] == SAT_MAX || res_ff[1] == SAT_MIN || res_ff[2] == SAT_MAX || res_ff[2] == SAT_MIN || res_ff[3] == SAT_MAX || res_ff[3] == SAT_MIN)

endmodule

`default_nettype wire

/* rtl/core/matrix_vector_transform_4x4_core.sv */
// Channel   Role       Payload                                   Handshake
// req_chan  in  sink   vec_x, vec_y, vec_z, vec_w (Q16.16)       valid/ready
// rsp_chan  out source out_x, out_y, out_z, out_w, clipped       valid/ready
// csr_*     in         csr_wr_en, csr_index[3:0], csr_wdata[63:0] write only
//
// One transaction per cycle sustained while the response is taken; four register stages lie
// between accept and rsp valid: multiplier bank, pair adders, row adders, floor/saturate.
// Reset clears every stage valid bit and loads the identity matrix.
// A stalled stage holds its data; req ready falls only when all four stages are full
// and the output is not being taken.
`default_nettype none
`include "matrix_vector_transform_4x4_core_defines.svh"

module matrix_vector_transform_4x4_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   mvt_req_if.sink                                  req_chan,
   mvt_rsp_if.source                                rsp_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [mvt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mvt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import mvt_pkg::*;

   mat_type      mat_ff;
   vec_type      vec;
   logic         mul_valid;
   logic         mul_ready;
   prod_mat_type prod;
   logic         sum_valid;
   logic         sum_ready;
   sum_vec_type  sums;
   vec_type      res;
   logic         clipped;
   comp_type     lo_word;
   comp_type     hi_word;

   assign lo_word = csr_wdata[DATA_W-1:0];
   assign hi_word = csr_wdata[CSR_DATA_W-1:DATA_W];

   // Matrix registers; out-of-map indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_ROWS; c++) begin
               mat_ff[r][c] <= (r == c) ? FIX_ONE : comp_type'(0);
            end
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ROW0_COLS01: begin
               mat_ff[0][0] <= lo_word;
               mat_ff[0][1] <= hi_word;
            end
            REG_ROW0_COLS23: begin
               mat_ff[0][2] <= lo_word;
               mat_ff[0][3] <= hi_word;
            end
            REG_ROW1_COLS01: begin
               mat_ff[1][0] <= lo_word;
               mat_ff[1][1] <= hi_word;
            end
            REG_ROW1_COLS23: begin
               mat_ff[1][2] <= lo_word;
               mat_ff[1][3] <= hi_word;
            end
            REG_ROW2_COLS01: begin
               mat_ff[2][0] <= lo_word;
               mat_ff[2][1] <= hi_word;
            end
            REG_ROW2_COLS23: begin
               mat_ff[2][2] <= lo_word;
               mat_ff[2][3] <= hi_word;
            end
            REG_ROW3_COLS01: begin
               mat_ff[3][0] <= lo_word;
               mat_ff[3][1] <= hi_word;
            end
            REG_ROW3_COLS23: begin
               mat_ff[3][2] <= lo_word;
               mat_ff[3][3] <= hi_word;
            end
            default: begin
               mat_ff <= mat_ff;
            end
         endcase
      end
   end

   assign vec[0] = req_chan.vec_x;
   assign vec[1] = req_chan.vec_y;
   assign vec[2] = req_chan.vec_z;
   assign vec[3] = req_chan.vec_w;

   mvt_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .valid_i (req_chan.valid),
      .ready_o (req_chan.ready),
      .vec_i   (vec),
      .mat_i   (mat_ff),
      .valid_o (mul_valid),
      .ready_i (mul_ready),
      .prod_o  (prod)
   );

   mvt_sum u_sum (
      .clock   (clock),
      .reset   (reset),
      .valid_i (mul_valid),
      .ready_o (mul_ready),
      .prod_i  (prod),
      .valid_o (sum_valid),
      .ready_i (sum_ready),
      .sum_o   (sums)
   );

   mvt_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .valid_i   (sum_valid),
      .ready_o   (sum_ready),
      .sum_i     (sums),
      .valid_o   (rsp_chan.valid),
      .ready_i   (rsp_chan.ready),
      .res_o     (res),
      .clipped_o (clipped)
   );

   assign rsp_chan.out_x   = res[0];
   assign rsp_chan.out_y   = res[1];
   assign rsp_chan.out_z   = res[2];
   assign rsp_chan.out_w   = res[3];
   assign rsp_chan.clipped = clipped;

   `MVT_ASSERT_NOW(a_ready_chain, clock, reset, rsp_chan.ready, req_chan.ready)
   `MVT_ASSERT_NEXT(a_csr_row0, clock, reset, csr_wr_en && csr_index == REG_ROW0_COLS01, mat_ff[0][0] == $past(lo_word) && mat_ff[0][1] == $past(hi_word))

endmodule

`default_nettype wire
